// File: rtl/core/utf8_stream_decoder_top_defines.svh
// Assertion helpers shared by the decoder RTL.
`ifndef UTF8_STREAM_DECODER_TOP_DEFINES_SVH
`define UTF8_STREAM_DECODER_TOP_DEFINES_SVH

// Check a condition on every clock edge once reset is released.
`define U8SD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define U8SD_ASSERT_SAME(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define U8SD_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/u8sd_pkg.sv
package u8sd_pkg;

  localparam int unsigned CP_W   = 31;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned TRL_W  = 3;
  localparam int unsigned BYTE_W = 8;

  // Lead byte class masks and the pattern each class must match
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'he0;
  localparam logic [7:0] LEAD2_PAT  = 8'hc0;
  localparam logic [7:0] LEAD3_MASK = 8'hf0;
  localparam logic [7:0] LEAD3_PAT  = 8'he0;
  localparam logic [7:0] LEAD4_MASK = 8'hf8;
  localparam logic [7:0] LEAD4_PAT  = 8'hf0;
  localparam logic [7:0] LEAD5_MASK = 8'hfc;
  localparam logic [7:0] LEAD5_PAT  = 8'hf8;
  localparam logic [7:0] LEAD6_MASK = 8'hfe;
  localparam logic [7:0] LEAD6_PAT  = 8'hfc;
  localparam logic [1:0] CONT_TAG   = 2'b10;

  typedef struct packed {
    logic             valid;
    logic [TRL_W-1:0] trails;
    logic [6:0]       payload;
  } lead_info_t;

  function automatic lead_info_t lead_decode(input logic [BYTE_W-1:0] b);
    lead_info_t info;
    info = '0;
    if ((b & ASCII_MASK) == 8'h00) begin
      info = '{valid: 1'b1, trails: 3'd0, payload: b[6:0]};
    end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
      info = '{valid: 1'b1, trails: 3'd1, payload: {2'b00, b[4:0]}};
    end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
      info = '{valid: 1'b1, trails: 3'd2, payload: {3'b000, b[3:0]}};
    end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
      info = '{valid: 1'b1, trails: 3'd3, payload: {4'b0000, b[2:0]}};
    end else if ((b & LEAD5_MASK) == LEAD5_PAT) begin
      info = '{valid: 1'b1, trails: 3'd4, payload: {5'b00000, b[1:0]}};
    end else if ((b & LEAD6_MASK) == LEAD6_PAT) begin
      info = '{valid: 1'b1, trails: 3'd5, payload: {6'b000000, b[0]}};
    end
    return info;
  endfunction

endpackage

// File: rtl/core/utf8_stream_decoder_top.sv
// Streaming UTF-8 decoder for the original six-byte form: one byte per input
// transaction, one 31-bit code point per completed character, and one end
// transaction (out_tuser high) carrying the character count and the offset
// past the last complete character when a zero byte arrives. Bytes enter an
// input register and are decoded combinationally against the sequence
// registers into the result register, so the block takes one byte per clock
// while out_tready accepts results; a held result stalls the input. The rate
// is set by the update of the sequence state (trail count, accumulator,
// counters). Invalid leads, broken sequences and multi-byte zeros are consumed
// with no result. Counters saturate at the smaller of MAX_LENGTH and 65535.
`include "utf8_stream_decoder_top_defines.svh"

module utf8_stream_decoder_top #(
  parameter longint unsigned MAX_LENGTH = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [30:0] code_point, [46:31] char_total,
                                  // [62:47] rest_offset, [63] zero
  output logic        out_tuser   // [0] is_end
);

  localparam int unsigned CP_W  = u8sd_pkg::CP_W;
  localparam int unsigned CNT_W = u8sd_pkg::CNT_W;
  localparam int unsigned TRL_W = u8sd_pkg::TRL_W;
  localparam logic [CNT_W-1:0] CNT_LIMIT =
    (MAX_LENGTH < 64'd65535) ? CNT_W'(MAX_LENGTH) : {CNT_W{1'b1}};

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v >= CNT_LIMIT) ? CNT_LIMIT : v + 1'b1;
  endfunction

  // Input stage
  logic                  stg_valid_r;
  logic [7:0]            stg_byte_r;

  // Sequence state
  logic [TRL_W-1:0]      trail_left_r, trail_left_nxt;
  logic [TRL_W-1:0]      seq_trails_r, seq_trails_nxt;
  logic [CP_W-1:0]       accum_r, accum_nxt;
  logic [CNT_W-1:0]      char_count_r, char_count_nxt;
  logic [CNT_W-1:0]      byte_pos_r, byte_pos_nxt;
  logic [CNT_W-1:0]      last_pos_r, last_pos_nxt;

  // Result register
  logic                  out_valid_r;
  logic [CP_W-1:0]       out_code_r;
  logic                  out_end_r;
  logic [CNT_W-1:0]      out_total_r;
  logic [CNT_W-1:0]      out_offset_r;

  logic                  emit;
  logic                  res_end;
  logic [CP_W-1:0]       res_code;
  logic [CNT_W-1:0]      res_total;
  logic [CNT_W-1:0]      res_offset;
  logic                  complete;
  logic                  out_free;
  logic                  advance;
  u8sd_pkg::lead_info_t  lead;

  logic                  term_taken;
  logic                  state_clear;
  logic                  char_fields_ok;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = stg_valid_r && (!emit || out_free);
  assign in_tready = !stg_valid_r || advance;

  always_comb begin
    trail_left_nxt = trail_left_r;
    seq_trails_nxt = seq_trails_r;
    accum_nxt      = accum_r;
    char_count_nxt = char_count_r;
    byte_pos_nxt   = byte_pos_r;
    last_pos_nxt   = last_pos_r;
    emit           = 1'b0;
    res_end        = 1'b0;
    res_code       = '0;
    res_total      = '0;
    res_offset     = '0;
    complete       = 1'b0;
    lead           = u8sd_pkg::lead_decode(stg_byte_r);

    if (stg_byte_r == 8'h00) begin
      // Terminator: report the string summary and clear for the next string
      emit           = 1'b1;
      res_end        = 1'b1;
      res_total      = char_count_r;
      res_offset     = last_pos_r;
      trail_left_nxt = '0;
      seq_trails_nxt = '0;
      accum_nxt      = '0;
      char_count_nxt = '0;
      byte_pos_nxt   = '0;
      last_pos_nxt   = '0;
    end else begin
      byte_pos_nxt = sat_inc(byte_pos_r);
      if (trail_left_r == '0) begin
        if (lead.valid) begin
          seq_trails_nxt = lead.trails;
          trail_left_nxt = lead.trails;
          accum_nxt      = {{(CP_W-7){1'b0}}, lead.payload};
          complete       = (lead.trails == '0);
        end
      end else if (stg_byte_r[7:6] != u8sd_pkg::CONT_TAG) begin
        // Broken sequence: drop the partial character and this byte
        trail_left_nxt = '0;
      end else begin
        trail_left_nxt = trail_left_r - 1'b1;
        accum_nxt      = {accum_r[CP_W-7:0], stg_byte_r[5:0]};
        complete       = (trail_left_r == TRL_W'(1));
      end

      if (complete) begin
        last_pos_nxt = sat_inc(byte_pos_r);
        // Drop a zero spelled with a multi-byte form
        if (!(seq_trails_nxt != '0 && accum_nxt == '0)) begin
          char_count_nxt = sat_inc(char_count_r);
          emit           = 1'b1;
          res_code       = accum_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r  <= 1'b0;
      trail_left_r <= '0;
      seq_trails_r <= '0;
      accum_r      <= '0;
      char_count_r <= '0;
      byte_pos_r   <= '0;
      last_pos_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_tready) begin
        stg_valid_r <= in_tvalid;
      end
      if (advance) begin
        trail_left_r <= trail_left_nxt;
        seq_trails_r <= seq_trails_nxt;
        accum_r      <= accum_nxt;
        char_count_r <= char_count_nxt;
        byte_pos_r   <= byte_pos_nxt;
        last_pos_r   <= last_pos_nxt;
      end
      if (out_free) begin
        out_valid_r <= advance && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_byte_r <= in_tdata;
    end
    if (out_free && advance && emit) begin
      out_code_r   <= res_code;
      out_end_r    <= res_end;
      out_total_r  <= res_total;
      out_offset_r <= res_offset;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_offset_r, out_total_r, out_code_r};
  assign out_tuser  = out_end_r;

  assign term_taken     = advance && (stg_byte_r == 8'h00);
  assign state_clear    = (byte_pos_r == '0) && (trail_left_r == '0) && (char_count_r == '0);
  assign char_fields_ok = (out_total_r == '0) && (out_offset_r == '0) && (out_code_r != '0);

  `U8SD_ASSERT_ALWAYS(a_trail_range, trail_left_r <= TRL_W'(5), "trail count out of range")
  `U8SD_ASSERT_ALWAYS(a_offset_order, last_pos_r <= byte_pos_r, "offset passed byte position")
  `U8SD_ASSERT_NEXT(a_end_clears, term_taken, state_clear, "state not cleared after terminator")
  `U8SD_ASSERT_SAME(a_char_fields, out_valid_r && !out_end_r, char_fields_ok, "bad char fields")

endmodule
